>>> sv/rhqk_pkg.sv
// rhqk_pkg: shared types and constants for the quad-key hash table.
// No dependencies.
package rhqk_pkg;
  localparam int TABLE_SLOTS = 1024;
  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [63:0] HASH_MUL = 64'hC6A4A7935BD1E995;
  localparam logic [63:0] HASH_ADD = 64'h00000000e6546b64;
  localparam int HASH_SHIFT = 47;
  localparam logic [7:0] EMPTY_DIST = 8'hFF;
  localparam logic [10:0] LOAD_RESET = 11'd768;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_HASH, S_RD, S_LK, S_FIT, S_CM, S_OUT
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic hash_go;
    logic pos_home;
    logic rd;
    logic adv;
    logic wr_carry;
    logic swap;
    logic set_res;
    logic [1:0] res_status;
    logic res_hit;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hash_done;
    logic is_empty;
    logic dist_eq;
    logic dist_gt;
    logic key_match;
    logic run;
    logic steps_done;
    logic dist_ovf;
    logic fit_ovf;
    logic full;
  } sts_t;
endpackage

>>> sv/rhqk_hash.sv
// rhqk_hash: iterative four-round multiply-xorshift-multiply key mixer.
// Depends on rhqk_pkg. At most one 64-bit multiply per cycle, cut into 32-bit partials.
module rhqk_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] key_a,
  input  logic [31:0] key_b,
  input  logic [31:0] key_c,
  input  logic [31:0] key_d,
  output logic        done,
  output logic [63:0] hash
);
  // per round: step 0 m=k*F, 1 m^=m>>47, m*=F, 2 seed^=m, seed*=F, 3 +ADD
  logic [1:0] rnd_r, rnd_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic busy_r, busy_nxt;
  logic done_r;
  logic [63:0] m_r, m_nxt, s_r, s_nxt;
  logic [63:0] opa;
  logic [63:0] prod;
  logic [31:0] k;
  logic [63:0] p0, p1, p2;

  always_comb begin
    case (rnd_r)
      2'd0: k = key_a;
      2'd1: k = key_b;
      2'd2: k = key_c;
      default: k = key_d;
    endcase
  end

  always_comb begin
    case (ph_r)
      3'd0: opa = {32'd0, k};
      3'd1: opa = m_r ^ (m_r >> rhqk_pkg::HASH_SHIFT);
      default: opa = s_r ^ m_r;
    endcase
  end

  assign p0 = opa[31:0] * rhqk_pkg::HASH_MUL[31:0];
  assign p1 = opa[63:32] * rhqk_pkg::HASH_MUL[31:0];
  assign p2 = opa[31:0] * rhqk_pkg::HASH_MUL[63:32];
  assign prod = p0 + {p1[31:0], 32'd0} + {p2[31:0], 32'd0};

  always_comb begin
    rnd_nxt = rnd_r;
    ph_nxt = ph_r;
    busy_nxt = busy_r;
    m_nxt = m_r;
    s_nxt = s_r;
    if (go) begin
      busy_nxt = 1'b1;
      rnd_nxt = 2'd0;
      ph_nxt = 3'd0;
      s_nxt = 64'd0;
    end else if (busy_r) begin
      case (ph_r)
        3'd0: begin
          m_nxt = prod;
          ph_nxt = 3'd1;
        end
        3'd1: begin
          m_nxt = prod;
          ph_nxt = 3'd2;
        end
        3'd2: begin
          s_nxt = prod;
          ph_nxt = 3'd3;
        end
        default: begin
          s_nxt = s_r + rhqk_pkg::HASH_ADD;
          ph_nxt = 3'd0;
          rnd_nxt = rnd_r + 2'd1;
          if (rnd_r == 2'd3) busy_nxt = 1'b0;
        end
      endcase
    end
  end

  assign hash = s_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r <= 2'd0;
      ph_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r <= rnd_nxt;
      ph_r <= ph_nxt;
      done_r <= busy_r && !busy_nxt;
    end
    m_r <= m_nxt;
    s_r <= s_nxt;
  end
endmodule

>>> sv/rhqk_datapath.sv
// rhqk_datapath: slot memories, carried entry, probe position, result regs.
// Depends on rhqk_pkg and rhqk_hash.
module rhqk_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  rhqk_pkg::cmd_t   cmd,
  output rhqk_pkg::sts_t   sts,
  input  logic [31:0]      key_a,
  input  logic [31:0]      key_b,
  input  logic [31:0]      key_c,
  input  logic [31:0]      key_d,
  input  logic [31:0]      new_value,
  input  logic [10:0]      load_limit,
  output logic             out_hit,
  output logic [31:0]      out_found_value,
  output logic [1:0]       out_status
);
  localparam int IW = rhqk_pkg::IDX_W;
  localparam int CW = rhqk_pkg::CNT_W;
  localparam int ENT_W = 64 + 4 * 32 + 32;

  logic [7:0] mem_dist [rhqk_pkg::TABLE_SLOTS];
  logic [ENT_W-1:0] mem_ent [rhqk_pkg::TABLE_SLOTS];
  logic [7:0] rd_dist_r;
  logic [ENT_W-1:0] rd_ent_r;

  logic [ENT_W-1:0] car_r, car_nxt, key_r;
  logic [7:0] cdist_r, cdist_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] cnt_r;
  logic [IW:0] clr_r;
  logic run_r;
  logic hdone;
  logic [63:0] hval;
  logic hit_r;
  logic [31:0] fv_r;
  logic [1:0] st_r;
  logic [7:0] wdist;
  logic [ENT_W-1:0] went;
  logic [IW-1:0] waddr;
  logic we;

  rhqk_hash u_hash (
    .clk(clk), .rst_n(rst_n), .go(cmd.hash_go),
    .key_a(key_r[159:128]), .key_b(key_r[127:96]),
    .key_c(key_r[95:64]), .key_d(key_r[63:32]),
    .done(hdone), .hash(hval)
  );

  // entry layout: hash, a, b, c, d, value
  always_comb begin
    car_nxt = car_r;
    cdist_nxt = cdist_r;
    pos_nxt = pos_r;
    steps_nxt = steps_r;
    if (cmd.load) begin
      car_nxt = {64'd0, key_a, key_b, key_c, key_d, new_value};
    end
    if (cmd.pos_home) begin
      car_nxt = {hval, key_r[159:0]};
      pos_nxt = hval[IW-1:0];
      cdist_nxt = 8'd0;
      steps_nxt = '0;
    end
    if (cmd.swap) begin
      car_nxt = rd_ent_r;
      cdist_nxt = rd_dist_r;
    end
    if (cmd.adv) begin
      cdist_nxt = (cmd.swap ? rd_dist_r : cdist_r) + 8'd1;
      pos_nxt = pos_r + 1'b1;
      steps_nxt = steps_r + 1'b1;
    end
  end

  always_comb begin
    we = cmd.clr_wr | cmd.wr_carry;
    waddr = cmd.clr_wr ? clr_r[IW-1:0] : pos_r;
    wdist = cmd.clr_wr ? rhqk_pkg::EMPTY_DIST : cdist_r;
    went = car_r;
  end

  // read targets the slot the probe moves to
  always_ff @(posedge clk) begin
    if (we) mem_dist[waddr] <= wdist;
    if (cmd.wr_carry) mem_ent[waddr] <= went;
    if (cmd.rd) begin
      rd_dist_r <= mem_dist[pos_nxt];
      rd_ent_r <= mem_ent[pos_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      cnt_r <= '0;
      run_r <= 1'b0;
      hit_r <= 1'b0;
      fv_r <= 32'd0;
      st_r <= rhqk_pkg::ST_OK;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (cmd.pos_home) run_r <= 1'b0;
      else if (cmd.adv && sts.dist_eq) run_r <= 1'b1;
      if (cmd.set_res) begin
        hit_r <= cmd.res_hit;
        fv_r <= cmd.res_hit ? rd_ent_r[31:0] : 32'd0;
        st_r <= cmd.res_status;
      end
    end
    if (cmd.load) key_r <= {64'd0, key_a, key_b, key_c, key_d, new_value};
    car_r <= car_nxt;
    cdist_r <= cdist_nxt;
    pos_r <= pos_nxt;
    steps_r <= steps_nxt;
  end

  assign sts.clr_done = clr_r[IW];
  assign sts.hash_done = hdone;
  assign sts.is_empty = rd_dist_r == rhqk_pkg::EMPTY_DIST;
  assign sts.dist_eq = rd_dist_r == cdist_r;
  assign sts.dist_gt = cdist_r > rd_dist_r;
  assign sts.key_match = rd_ent_r[ENT_W-1:32] == car_r[ENT_W-1:32];
  assign sts.run = run_r;
  assign sts.steps_done = steps_r == CW'(rhqk_pkg::TABLE_SLOTS - 1);
  assign sts.dist_ovf = cdist_r == 8'd254;
  // dry run: next carried distance min(cd, sd)+1 reaching 255
  assign sts.fit_ovf = (sts.dist_gt ? rd_dist_r : cdist_r) == 8'd254;
  assign sts.full = ({1'b0, cnt_r} + 1'b1 > {{(CW + 1 - 11) {1'b0}}, load_limit})
                    || (cnt_r >= CW'(rhqk_pkg::TABLE_SLOTS));

  assign out_hit = hit_r;
  assign out_found_value = fv_r;
  assign out_status = st_r;
endmodule

>>> sv/rhqk_ctrl.sv
// rhqk_ctrl: sequencer for clear, hash, lookup walk, dry run and commit.
// Depends on rhqk_pkg.
module rhqk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_opcode,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           cm_start,
  input  logic           cm_done,
  output rhqk_pkg::cmd_t cmd,
  input  rhqk_pkg::sts_t sts
);
  rhqk_pkg::state_t st_r, st_nxt;
  logic op_r;

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cm_start = 1'b0;
    unique case (st_r)
      rhqk_pkg::S_CLEAR: begin
        cmd.clr_wr = !sts.clr_done;
        if (sts.clr_done) st_nxt = rhqk_pkg::S_IDLE;
      end
      rhqk_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.hash_go = 1'b1;
          st_nxt = rhqk_pkg::S_HASH;
        end
      end
      rhqk_pkg::S_HASH: begin
        if (sts.hash_done) begin
          cmd.pos_home = 1'b1;
          if (op_r && sts.full) begin
            cmd.set_res = 1'b1;
            cmd.res_status = rhqk_pkg::ST_FULL;
            st_nxt = rhqk_pkg::S_OUT;
          end else begin
            st_nxt = rhqk_pkg::S_RD;
          end
        end
      end
      rhqk_pkg::S_RD: begin
        cmd.rd = 1'b1;
        st_nxt = op_r ? rhqk_pkg::S_FIT : rhqk_pkg::S_LK;
      end
      rhqk_pkg::S_LK: begin
        cmd.set_res = 1'b1;
        cmd.res_status = rhqk_pkg::ST_OK;
        if (sts.is_empty) st_nxt = rhqk_pkg::S_OUT;
        else if (sts.dist_eq && sts.key_match) begin
          cmd.res_hit = 1'b1;
          st_nxt = rhqk_pkg::S_OUT;
        end else if (!sts.dist_eq && sts.run) st_nxt = rhqk_pkg::S_OUT;
        else if (sts.dist_ovf || sts.steps_done) st_nxt = rhqk_pkg::S_OUT;
        else begin
          cmd.set_res = 1'b0;
          cmd.adv = 1'b1;
          cmd.rd = 1'b1;
        end
      end
      rhqk_pkg::S_FIT: begin
        if (sts.is_empty) begin
          cmd.pos_home = 1'b1;
          cm_start = 1'b1;
          st_nxt = rhqk_pkg::S_CM;
        end else if (sts.fit_ovf || sts.steps_done) begin
          cmd.set_res = 1'b1;
          cmd.res_status = rhqk_pkg::ST_OVF;
          st_nxt = rhqk_pkg::S_OUT;
        end else begin
          if (sts.dist_gt) cmd.swap = 1'b1;
          cmd.adv = 1'b1;
          cmd.rd = 1'b1;
        end
      end
      rhqk_pkg::S_CM: begin
        // displacement walk owns the datapath until done
        if (cm_done) st_nxt = rhqk_pkg::S_OUT;
      end
      rhqk_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_nxt = rhqk_pkg::S_IDLE;
      end
      default: st_nxt = rhqk_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rhqk_pkg::S_CLEAR;
      op_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_valid && in_ready) op_r <= in_opcode;
    end
  end
endmodule

>>> sv/rhqk_commit.sv
// rhqk_commit: sequencer for the displacement walk of a fitting insert.
// Depends on rhqk_pkg; drives the datapath while its parent is in commit.
module rhqk_commit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  rhqk_pkg::sts_t sts,
  output rhqk_pkg::cmd_t cmd,
  output logic           done
);
  logic [1:0] ph_r, ph_nxt;
  logic busy_r, busy_nxt;
  // ph 0: issue read, ph 1: data ready, act
  always_comb begin
    cmd = '0;
    done = 1'b0;
    ph_nxt = ph_r;
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
      ph_nxt = 2'd0;
    end else if (busy_r) begin
      case (ph_r)
        2'd0: begin
          cmd.rd = 1'b1;
          ph_nxt = 2'd1;
        end
        default: begin
          if (sts.is_empty) begin
            cmd.wr_carry = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.set_res = 1'b1;
            cmd.res_status = rhqk_pkg::ST_OK;
            busy_nxt = 1'b0;
            done = 1'b1;
          end else begin
            if (sts.dist_gt) begin
              cmd.wr_carry = 1'b1;
              cmd.swap = 1'b1;
            end
            cmd.adv = 1'b1;
            ph_nxt = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      ph_r <= ph_nxt;
    end
  end
endmodule

>>> sv/robin_hood_quad_key_table.sv
// robin_hood_quad_key_table: Robin Hood hash table keyed by four identifiers.
// Flow: accept, hash; a refused insert then goes straight to its result. Otherwise the
// home slot is read, slots are probed one by one for lookup and dry run, each slot of the
// commit walk takes a read and then an act, and the result is presented.
// Throughput: one item at a time; the next is taken only once the result is accepted.
// Reset: synchronous active low; a clearing pass over all 1024 slots empties the
// distance store before the first item is accepted. Config writes always taken.
module robin_hood_quad_key_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_key_a,
  input  logic [31:0] in_key_b,
  input  logic [31:0] in_key_c,
  input  logic [31:0] in_key_d,
  input  logic [31:0] in_new_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [31:0] out_found_value,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_load_limit
);
  rhqk_pkg::cmd_t c_cmd, m_cmd, cmd;
  rhqk_pkg::sts_t sts;
  logic [10:0] limit_r;
  logic in_cm_r, cm_start, m_done;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= rhqk_pkg::LOAD_RESET;
    else if (cfg_valid) limit_r <= cfg_load_limit;
  end

  rhqk_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .out_valid(out_valid), .out_ready(out_ready),
    .cm_start(cm_start), .cm_done(m_done), .cmd(c_cmd), .sts(sts)
  );

  rhqk_commit u_cm (
    .clk(clk), .rst_n(rst_n), .start(cm_start), .sts(sts), .cmd(m_cmd), .done(m_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) in_cm_r <= 1'b0;
    else if (cm_start) in_cm_r <= 1'b1;
    else if (m_done) in_cm_r <= 1'b0;
  end

  assign cmd = in_cm_r ? m_cmd : c_cmd;

  rhqk_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .key_a(in_key_a), .key_b(in_key_b), .key_c(in_key_c), .key_d(in_key_d),
    .new_value(in_new_value), .load_limit(limit_r),
    .out_hit(out_hit), .out_found_value(out_found_value), .out_status(out_status)
  );
endmodule

>>> sv/rhqk_checker.sv
// rhqk_checker: port-level assertions for robin_hood_quad_key_table.
// Depends on nothing; bound to the top level below.
module rhqk_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit,
  input logic [31:0] out_found_value,
  input logic [1:0] out_status
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_value))
    else $error("result dropped");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_value == 32'd0) else $error("miss value");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
endmodule

bind robin_hood_quad_key_table rhqk_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
  .out_found_value(out_found_value), .out_status(out_status)
);

>>> dv/tb_robin_hood_quad_key_table.sv
// Testbench for robin_hood_quad_key_table: drives lookups and inserts, predicts
// hit/value/status with an in-bench Robin Hood table model. Depends on rhqk_pkg.
module tb_robin_hood_quad_key_table;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        hit;
    logic [31:0] value;
    logic [1:0]  status;
  } table_result_t;

  class table_scoreboard;
    logic [7:0]  dist_q [rhqk_pkg::TABLE_SLOTS];
    logic [63:0] hash_q [rhqk_pkg::TABLE_SLOTS];
    logic [31:0] ka [rhqk_pkg::TABLE_SLOTS], kb [rhqk_pkg::TABLE_SLOTS];
    logic [31:0] kc [rhqk_pkg::TABLE_SLOTS], kd [rhqk_pkg::TABLE_SLOTS];
    logic [31:0] val_q [rhqk_pkg::TABLE_SLOTS];
    int unsigned entries;
    int unsigned limit;
    table_result_t pending[$];
    int errors;
    int hits, refusals, overflows, results;

    function void clear();
      for (int i = 0; i < rhqk_pkg::TABLE_SLOTS; i++) dist_q[i] = rhqk_pkg::EMPTY_DIST;
      entries = 0;
      limit = rhqk_pkg::LOAD_RESET;
    endfunction

    function logic [63:0] mix(logic [63:0] s, logic [31:0] k);
      logic [63:0] m;
      m = {32'd0, k} * rhqk_pkg::HASH_MUL;
      m = m ^ (m >> rhqk_pkg::HASH_SHIFT);
      m = m * rhqk_pkg::HASH_MUL;
      s = s ^ m;
      s = s * rhqk_pkg::HASH_MUL;
      return s + rhqk_pkg::HASH_ADD;
    endfunction

    function bit fits(logic [63:0] h);
      int p, d;
      p = h[rhqk_pkg::IDX_W-1:0];
      d = 0;
      for (int n = 0; n < rhqk_pkg::TABLE_SLOTS; n++) begin
        if (dist_q[p] == rhqk_pkg::EMPTY_DIST) return 1;
        if (d > dist_q[p]) d = dist_q[p];
        d++;
        if (d >= 255) return 0;
        p = (p + 1) % rhqk_pkg::TABLE_SLOTS;
      end
      return 0;
    endfunction

    function void note_word(logic op, logic [31:0] a, b, c, d, v);
      table_result_t r;
      logic [63:0] h, th;
      logic [31:0] t0, t1, t2, t3, tv;
      int p, dd;
      bit run;
      logic [7:0] sd;
      r = '{1'b0, 32'd0, rhqk_pkg::ST_OK};
      h = mix(mix(mix(mix(64'd0, a), b), c), d);
      p = h[rhqk_pkg::IDX_W-1:0];
      if (!op) begin
        run = 0;
        dd = 0;
        for (int n = 0; n < rhqk_pkg::TABLE_SLOTS && dd < 255; n++) begin
          sd = dist_q[p];
          if (sd == rhqk_pkg::EMPTY_DIST) break;
          if (dd == sd) begin
            run = 1;
            if (hash_q[p] == h && ka[p] == a && kb[p] == b && kc[p] == c && kd[p] == d)
            begin
              r.hit = 1;
              r.value = val_q[p];
              break;
            end
          end else if (run) break;
          dd++;
          p = (p + 1) % rhqk_pkg::TABLE_SLOTS;
        end
      end else if (entries + 1 > limit || entries >= rhqk_pkg::TABLE_SLOTS) begin
        r.status = rhqk_pkg::ST_FULL;
      end else if (!fits(h)) begin
        r.status = rhqk_pkg::ST_OVF;
      end else begin
        dd = 0;
        for (int n = 0; n < rhqk_pkg::TABLE_SLOTS; n++) begin
          sd = dist_q[p];
          if (sd == rhqk_pkg::EMPTY_DIST) begin
            dist_q[p] = 8'(dd); hash_q[p] = h; ka[p] = a; kb[p] = b; kc[p] = c; kd[p] = d;
            val_q[p] = v;
            break;
          end
          if (dd > sd) begin
            dist_q[p] = 8'(dd); dd = sd;
            th = hash_q[p]; hash_q[p] = h; h = th;
            t0 = ka[p]; ka[p] = a; a = t0;
            t1 = kb[p]; kb[p] = b; b = t1;
            t2 = kc[p]; kc[p] = c; c = t2;
            t3 = kd[p]; kd[p] = d; d = t3;
            tv = val_q[p]; val_q[p] = v; v = tv;
          end
          dd++;
          p = (p + 1) % rhqk_pkg::TABLE_SLOTS;
        end
        entries++;
      end
      pending.push_back(r);
    endfunction

    function void check_word(logic hit, logic [31:0] value, logic [1:0] status);
      table_result_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t unexpected result hit=%0d value=%h status=%0d", $time, hit, value,
                 status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.hit) hits++;
      if (e.status == rhqk_pkg::ST_FULL) refusals++;
      if (e.status == rhqk_pkg::ST_OVF) overflows++;
      if (hit !== e.hit) begin
        $display("%0t hit mismatch exp %0d got %0d", $time, e.hit, hit);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t found_value mismatch exp %h got %h", $time, e.value, value);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t status mismatch exp %0d got %0d", $time, e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, in_opcode = 0;
  logic [31:0] in_key_a = 0, in_key_b = 0, in_key_c = 0, in_key_d = 0, in_new_value = 0;
  logic out_valid, out_ready = 0, out_hit;
  logic [31:0] out_found_value;
  logic [1:0] out_status;
  logic cfg_valid = 0, cfg_ready;
  logic [10:0] cfg_load_limit = 0;

  table_scoreboard sb;
  logic [31:0] key_pool [64][4];
  int cycles = 0;
  int stall_mode = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  robin_hood_quad_key_table dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 20000000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: checks each accepted result under a randomly redrawn stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_hit, out_found_value, out_status);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= cycles[2];
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
  end

  task automatic send_word(logic op, logic [31:0] a, b, c, d, v);
    in_valid <= 1; in_opcode <= op;
    in_key_a <= a; in_key_b <= b; in_key_c <= c; in_key_d <= d; in_new_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, a, b, c, d, v);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    int waited;
    in_valid <= 0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [10:0] lim);
    cfg_valid <= 1;
    cfg_load_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = lim;
    cfg_valid <= 0;
  endtask

  task automatic pool_word(bit ins);
    int k;
    k = $urandom_range(0, 63);
    send_word(ins, key_pool[k][0], key_pool[k][1], key_pool[k][2], key_pool[k][3],
              $urandom());
  endtask

  task automatic random_phase(int count, int ins_pct);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && count > 0; i++, count--) begin
        if ($urandom_range(0, 9) == 0)
          send_word(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
        else
          pool_word($urandom_range(0, 99) < ins_pct);
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.clear();
    for (int i = 0; i < 64; i++)
      for (int j = 0; j < 4; j++)
        key_pool[i][j] = (i < 4) ? {32{i[0]}} ^ (j * 32'h1) : $urandom();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, lookup miss on empty, insert, hit, duplicate insert
    send_word(0, 0, 0, 0, 0, 0);
    send_word(1, 0, 0, 0, 0, 32'hFFFFFFFF);
    send_word(0, 0, 0, 0, 0, 0);
    send_word(1, '1, '1, '1, '1, 32'h0);
    send_word(0, '1, '1, '1, '1, 32'h12345678);
    send_word(1, 0, 0, 0, 0, 32'hA5A5A5A5);
    send_word(0, 0, 0, 0, 0, 0);
    send_word(0, 0, 0, 0, 1, 0);
    send_word(0, 32'h80000000, 1, 2, 3, 0);
    drain();

    // tight load limit: inserts past it refused
    write_limit(11'd4);
    for (int i = 0; i < 4; i++) send_word(1, i, i + 1, i + 2, i + 3, i);
    send_word(0, 1, 2, 3, 4, 0);
    drain();

    write_limit(11'd1024);
    random_phase(400, 70);
    write_limit(11'd1);
    random_phase(100, 50);
    write_limit(11'd2047);
    random_phase(700, 85);
    write_limit(11'd768);
    random_phase(300, 30);

    $display("covered %0d results: %0d hits, %0d load refusals, %0d distance overflows",
             sb.results, sb.hits, sb.refusals, sb.overflows);
    $display("table ended with %0d entries", sb.entries);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
